// ===== hw/rtl/scaled_glyph_text_rasterizer_unit_macros.svh =====
// Assertion macros used by the checker file of the text rasterizer.
`ifndef SCALED_GLYPH_TEXT_RASTERIZER_UNIT_MACROS_SVH
`define SCALED_GLYPH_TEXT_RASTERIZER_UNIT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define SGTR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Concurrent assertion that is also checked while reset is asserted.
`define SGTR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/sgtr_pkg.sv =====
// Types, constants and the 5x7 glyph table of the text rasterizer.
`default_nettype none

package sgtr_pkg;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;

  typedef enum logic {
    REG_GLYPH_SCALE = 1'b0,
    REG_INK_COLOR   = 1'b1
  } cfg_reg_e;

  localparam logic [3:0]  SCALE_RESET = 4'd1;
  localparam logic [31:0] COLOR_RESET = 32'hFFFF_FFFF;

  // Largest cursor coordinate; the cursor saturates here.
  localparam logic [12:0] POS_MAX = 13'd4095;

  // Last column and last row of a glyph cell.
  localparam logic [2:0] GLYPH_LAST_COL = 3'd4;
  localparam logic [2:0] GLYPH_LAST_ROW = 3'd6;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Row 0 is the top row; bit 4 of a row is the leftmost column.
  typedef logic [0:6][4:0] glyph_t;

  typedef struct packed {
    logic signed [12:0] cur_x;
    logic signed [12:0] cur_y;
    logic [3:0]         scale;
    logic [31:0]        color;
    glyph_t             rows;
  } job_t;

  typedef struct packed {
    logic [10:0] x;
    logic [9:0]  y;
    logic [3:0]  w;
    logic [3:0]  h;
  } rect_t;

  // Folds lower case to upper case and returns the glyph; unknown codes are blank.
  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    logic [7:0] folded;
    glyph_t     g;
    folded = (code >= 8'd97 && code <= 8'd122) ? code - 8'd32 : code;
    case (folded)
      8'd43: g = {5'd0, 5'd4, 5'd4, 5'd31, 5'd4, 5'd4, 5'd0};
      8'd45: g = {5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
      8'd46: g = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd6, 5'd6};
      8'd47: g = {5'd1, 5'd2, 5'd2, 5'd4, 5'd8, 5'd8, 5'd16};
      8'd48: g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      8'd49: g = {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      8'd50: g = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
      8'd51: g = {5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
      8'd52: g = {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
      8'd53: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30};
      8'd54: g = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      8'd55: g = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
      8'd56: g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      8'd57: g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd14};
      8'd58: g = {5'd0, 5'd4, 5'd4, 5'd0, 5'd4, 5'd4, 5'd0};
      8'd65: g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      8'd66: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      8'd67: g = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      8'd68: g = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      8'd69: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      8'd70: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      8'd71: g = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      8'd72: g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      8'd73: g = {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd31};
      8'd74: g = {5'd7, 5'd2, 5'd2, 5'd2, 5'd18, 5'd18, 5'd12};
      8'd75: g = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      8'd76: g = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      8'd77: g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      8'd78: g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      8'd79: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      8'd80: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      8'd81: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      8'd82: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      8'd83: g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
      8'd84: g = {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
      8'd85: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      8'd86: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      8'd87: g = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      8'd88: g = {5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17};
      8'd89: g = {5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4};
      8'd90: g = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sgtr_front.sv =====
// Front end: configuration registers, cursor state and request classification.
`default_nettype none

module sgtr_front import sgtr_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire                cfg_index_i,
  input  wire         [31:0] cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire                cmd_i,
  input  wire          [7:0] char_code_i,
  input  wire  signed [12:0] pos_x_i,
  input  wire  signed [12:0] pos_y_i,
  input  wire                q_full_i,
  output logic               q_push_o,
  output job_t               q_job_o
);

  logic [3:0]         scale_q, scale_d;
  logic [31:0]        color_q, color_d;
  logic signed [12:0] cur_x_q, cur_x_d;
  logic signed [12:0] cur_y_q, cur_y_d;
  logic signed [12:0] origin_x_q, origin_x_d;

  logic        accept;
  logic        is_newline;
  glyph_t      glyph;
  logic [13:0] sum_x;
  logic [13:0] sum_y;
  logic [12:0] adv_x;
  logic [12:0] adv_y;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_newline = (char_code_i == CHAR_NEWLINE);
  assign glyph      = glyph_lookup(char_code_i);

  // The cursor only ever advances by non-negative steps, so only the top needs saturation.
  assign sum_x = {cur_x_q[12], cur_x_q} + 14'(14'(scale_q) * 14'd6);
  assign sum_y = {cur_y_q[12], cur_y_q} + 14'(14'(scale_q) * 14'd9);
  assign adv_x = (!sum_x[13] && sum_x[12]) ? POS_MAX : sum_x[12:0];
  assign adv_y = (!sum_y[13] && sum_y[12]) ? POS_MAX : sum_y[12:0];

  assign q_push_o = accept && (cmd_i == CMD_DRAW) && !is_newline
                    && (glyph != '0) && (scale_q != '0);
  assign q_job_o  = '{cur_x: cur_x_q, cur_y: cur_y_q, scale: scale_q,
                      color: color_q, rows: glyph};

  always_comb begin
    scale_d    = scale_q;
    color_d    = color_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    origin_x_d = origin_x_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_GLYPH_SCALE: scale_d = cfg_data_i[3:0];
        REG_INK_COLOR:   color_d = cfg_data_i;
        default:         ;
      endcase
    end
    if (accept) begin
      if (cmd_i == CMD_SET) begin
        cur_x_d    = pos_x_i;
        cur_y_d    = pos_y_i;
        origin_x_d = pos_x_i;
      end else if (is_newline) begin
        cur_x_d = origin_x_q;
        cur_y_d = signed'(adv_y);
      end else begin
        cur_x_d = signed'(adv_x);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= SCALE_RESET;
      color_q    <= COLOR_RESET;
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      origin_x_q <= '0;
    end else begin
      scale_q    <= scale_d;
      color_q    <= color_d;
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      origin_x_q <= origin_x_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sgtr_queue.sv =====
// Short request queue between the front end and the raster back end.
`default_nettype none

module sgtr_queue import sgtr_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  job_t  job_i,
  output logic  full_o,
  output logic  valid_o,
  input  wire   pop_i,
  output job_t  job_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  job_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;

  assign full_o  = (count_q == (PtrW+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sgtr_back.sv =====
// Back end: walks the glyph dots, clips each rectangle and drives the result register.
`default_nettype none

module sgtr_back import sgtr_pkg::*; #(
  parameter int SCREEN_WIDTH  = 1280,
  parameter int SCREEN_HEIGHT = 720
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          q_valid_i,
  input  job_t         q_job_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output rect_t        out_rect_o,
  output logic  [31:0] out_color_o,
  output logic         out_last_o
);

  localparam logic signed [15:0] ScrW = 16'(SCREEN_WIDTH);
  localparam logic signed [15:0] ScrH = 16'(SCREEN_HEIGHT);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e      state_q, state_d;
  job_t        job_q, job_d;
  logic [2:0]  gx_q, gx_d;
  logic [2:0]  gy_q, gy_d;
  logic [5:0]  off_x_q, off_x_d;
  logic [6:0]  off_y_q, off_y_d;
  logic        pend_v_q, pend_v_d;
  rect_t       pend_q, pend_d;
  logic        out_valid_q, out_valid_d;
  rect_t       out_rect_q, out_rect_d;
  logic [31:0] out_color_q, out_color_d;
  logic        out_last_q, out_last_d;

  logic               out_free;
  logic               lit;
  logic               hit;
  logic signed [15:0] sc16;
  logic signed [15:0] x0, xl, wl, wr;
  logic signed [15:0] y0, yl, hl, hr;
  rect_t              cur_rect;

  assign out_free = !out_valid_q || out_ready_i;
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;

  // Clip the current dot's square against the screen edges.
  always_comb begin
    sc16 = signed'(16'(job_q.scale));
    x0   = 16'(job_q.cur_x) + 16'(off_x_q);
    y0   = 16'(job_q.cur_y) + 16'(off_y_q);
    xl   = x0[15] ? '0 : x0;
    wl   = x0[15] ? sc16 + x0 : sc16;
    yl   = y0[15] ? '0 : y0;
    hl   = y0[15] ? sc16 + y0 : sc16;
    wr   = (xl + wl > ScrW) ? ScrW - xl : wl;
    hr   = (yl + hl > ScrH) ? ScrH - yl : hl;
    lit  = job_q.rows[gy_q][GLYPH_LAST_COL - gx_q];
    hit  = lit && !wr[15] && (wr != '0) && !hr[15] && (hr != '0);
    cur_rect = '{x: xl[10:0], y: yl[9:0], w: wr[3:0], h: hr[3:0]};
  end

  // A found rectangle waits in the pending slot until the next one shows up, so
  // that the final one of a character can be marked when it leaves.
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    gx_d        = gx_q;
    gy_d        = gy_q;
    off_x_d     = off_x_q;
    off_y_d     = off_y_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rect_d  = out_rect_q;
    out_color_d = out_color_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          job_d    = q_job_i;
          gx_d     = '0;
          gy_d     = '0;
          off_x_d  = '0;
          off_y_d  = '0;
          pend_v_d = 1'b0;
          state_d  = ST_WALK;
        end
      end
      ST_WALK: begin
        if (out_free) begin
          if (hit) begin
            if (pend_v_q) begin
              out_valid_d = 1'b1;
              out_rect_d  = pend_q;
              out_color_d = job_q.color;
              out_last_d  = 1'b0;
            end
            pend_d   = cur_rect;
            pend_v_d = 1'b1;
          end
          if (gx_q == GLYPH_LAST_COL) begin
            gx_d    = '0;
            off_x_d = '0;
            gy_d    = gy_q + 3'd1;
            off_y_d = off_y_q + 7'(job_q.scale);
            if (gy_q == GLYPH_LAST_ROW) begin
              state_d = ST_FLUSH;
            end
          end else begin
            gx_d    = gx_q + 3'd1;
            off_x_d = off_x_q + 6'(job_q.scale);
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          if (pend_v_q) begin
            out_valid_d = 1'b1;
            out_rect_d  = pend_q;
            out_color_d = job_q.color;
            out_last_d  = 1'b1;
          end
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q       <= job_d;
    gx_q        <= gx_d;
    gy_q        <= gy_d;
    off_x_q     <= off_x_d;
    off_y_q     <= off_y_d;
    pend_q      <= pend_d;
    out_rect_q  <= out_rect_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rect_o  = out_rect_q;
  assign out_color_o = out_color_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/scaled_glyph_text_rasterizer_unit.sv =====
// Top level of the scaled 5x7 glyph text rasterizer.
`default_nettype none

// The unit turns a stream of text requests into clipped fill rectangles for a
// screen overlay. A set request (cmd 0) loads the cursor and the line origin; a
// draw request (cmd 1) looks the character up in a 5x7 upper-case font, lower
// case being folded to upper case and unknown codes drawing nothing, and emits
// one glyph_scale by glyph_scale rectangle per lit dot, top row first and left
// to right, clipped to SCREEN_WIDTH by SCREEN_HEIGHT. Rectangles that clip away
// are dropped, and last_rect marks the final rectangle of a character. A newline
// moves the cursor down 9*glyph_scale and back to the line origin; every other
// character moves it right by 6*glyph_scale, both saturating at +4095.
// The front end takes one request per cycle while the queue has room: set,
// newline and blank characters finish there, while a visible character is
// queued in a two-deep request queue. The raster back end takes a character
// from the queue while idle, walks all 35 dot positions whatever the number
// of lit dots, at one per cycle while the output register is free, and hands
// over the final rectangle in a flush state, taking no new character before
// it is idle again. Results leave through an output register; while a result
// waits there, the back end pauses its walk.
// Configuration writes take effect at once and belong in idle periods only.

module scaled_glyph_text_rasterizer_unit import sgtr_pkg::*; #(
  parameter int SCREEN_WIDTH  = 1280,
  parameter int SCREEN_HEIGHT = 720
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire                cfg_index_i,
  input  wire         [31:0] cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire                cmd_i,
  input  wire          [7:0] char_code_i,
  input  wire  signed [12:0] pos_x_i,
  input  wire  signed [12:0] pos_y_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic        [10:0] rect_x_o,
  output logic         [9:0] rect_y_o,
  output logic         [3:0] rect_w_o,
  output logic         [3:0] rect_h_o,
  output logic        [31:0] fill_color_o,
  output logic               last_rect_o
);

  logic  q_push;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  job_t  push_job;
  job_t  head_job;
  rect_t out_rect;

  // The front end snapshots cursor, scale and color into each queued request,
  // so the cursor can move on before the back end draws the character.
  sgtr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .char_code_i (char_code_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (push_job)
  );

  sgtr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .job_o   (head_job)
  );

  sgtr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (head_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rect_o  (out_rect),
    .out_color_o (fill_color_o),
    .out_last_o  (last_rect_o)
  );

  assign rect_x_o = out_rect.x;
  assign rect_y_o = out_rect.y;
  assign rect_w_o = out_rect.w;
  assign rect_h_o = out_rect.h;

endmodule

`default_nettype wire

// ===== hw/rtl/sgtr_checker.sv =====
// Port-level checker for the text rasterizer and its bind to the top level.
`default_nettype none

`include "scaled_glyph_text_rasterizer_unit_macros.svh"

module sgtr_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [10:0] rect_x_o,
  input wire  [9:0] rect_y_o,
  input wire  [3:0] rect_w_o,
  input wire  [3:0] rect_h_o,
  input wire [31:0] fill_color_o,
  input wire        last_rect_o
);

  // A stalled result holds still until it is taken.
  `SGTR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(rect_x_o) && $stable(rect_y_o) && $stable(fill_color_o) && $stable(last_rect_o))

  // Empty rectangles are dropped before they reach the output.
  `SGTR_ASSERT(a_rect_nonempty, clk_i, rst_ni, out_valid_o |-> rect_w_o != 4'd0 && rect_h_o != 4'd0)

  // Nothing is offered in the cycle after reset was seen low.
  `SGTR_ASSERT_ALWAYS(a_quiet_after_reset, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind scaled_glyph_text_rasterizer_unit sgtr_checker u_sgtr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .rect_x_o     (rect_x_o),
  .rect_y_o     (rect_y_o),
  .rect_w_o     (rect_w_o),
  .rect_h_o     (rect_h_o),
  .fill_color_o (fill_color_o),
  .last_rect_o  (last_rect_o)
);

`default_nettype wire
